@@ src/hpm_pkg.sv @@
// Package for the binary16 multiplier: constants, stage structures and helpers.
// No dependencies.
package hpm_pkg;

  localparam logic [15:0] HALF_POS_INF = 16'h7C00;
  localparam logic [15:0] HALF_NAN     = 16'h7FFF;
  localparam logic [15:0] HALF_NEG_INF = 16'hFC00;

  // Operands unpacked and special cases resolved.
  typedef struct packed {
    logic        valid;
    logic        sign;
    logic        special;
    logic [15:0] special_val;
    logic [10:0] ma;
    logic [10:0] mb;
    logic signed [7:0] xsum;
  } unpack_t;

  // Product of the significands.
  typedef struct packed {
    logic        valid;
    logic        sign;
    logic        special;
    logic [15:0] special_val;
    logic [21:0] p;
    logic signed [7:0] xsum;
  } mult_t;

  // Normalised and aligned product, ready for rounding.
  typedef struct packed {
    logic        valid;
    logic        sign;
    logic        special;
    logic [15:0] special_val;
    logic        sub;
    logic [11:0] q;
    logic        guard;
    logic        sticky;
    logic signed [7:0] be;
  } align_t;

  // Leading-zero normalisation of a subnormal fraction: the left shift that
  // brings its leading one up to the hidden-bit position.
  function automatic logic [3:0] lzc10(input logic [9:0] f);
    logic [3:0] n;
    n = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (f[i]) n = 4'(10 - i);
    end
    return n;
  endfunction

endpackage

@@ src/hpm_unpack.sv @@
// Stage one: operand decode, special cases, significand normalisation.
// Depends on hpm_pkg.
module hpm_unpack import hpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  output unpack_t     st_r
);
  unpack_t st_nxt;
  logic [4:0] ea, eb;
  logic [9:0] fa, fb;
  logic [3:0] la, lb;
  logic sgn, az, bz;

  always_comb begin
    ea = operand_a[14:10]; eb = operand_b[14:10];
    fa = operand_a[9:0];   fb = operand_b[9:0];
    sgn = operand_a[15] ^ operand_b[15];
    az = (ea == 5'd0) && (fa == 10'd0);
    bz = (eb == 5'd0) && (fb == 10'd0);
    la = lzc10(fa); lb = lzc10(fb);
    st_nxt = '0;
    st_nxt.valid = in_valid;
    st_nxt.sign = sgn;
    if (((ea == 5'd31) && (fa != 10'd0)) || ((eb == 5'd31) && (fb != 10'd0))) begin
      st_nxt.special = 1'b1; st_nxt.special_val = HALF_NAN;
    end else if ((ea == 5'd31) || (eb == 5'd31)) begin
      st_nxt.special = 1'b1;
      st_nxt.special_val = (az || bz) ? HALF_NAN : (sgn ? HALF_NEG_INF : HALF_POS_INF);
    end else if (az || bz) begin
      st_nxt.special = 1'b1; st_nxt.special_val = {sgn, 15'd0};
    end
    if (ea != 5'd0) st_nxt.ma = {1'b1, fa};
    else            st_nxt.ma = 11'({1'b0, fa} << la);
    if (eb != 5'd0) st_nxt.mb = {1'b1, fb};
    else            st_nxt.mb = 11'({1'b0, fb} << lb);
    st_nxt.xsum = ((ea != 5'd0) ? 8'(signed'({3'd0, ea}) - 8'sd15) : 8'(-8'sd14 - signed'({4'd0, la})))
                + ((eb != 5'd0) ? 8'(signed'({3'd0, eb}) - 8'sd15) : 8'(-8'sd14 - signed'({4'd0, lb})));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    {st_r.sign, st_r.special, st_r.special_val, st_r.ma, st_r.mb, st_r.xsum} <=
      {st_nxt.sign, st_nxt.special, st_nxt.special_val, st_nxt.ma, st_nxt.mb, st_nxt.xsum};
  end
endmodule

@@ src/hpm_multiply.sv @@
// Stage two: 11 by 11 significand multiply.
// Depends on hpm_pkg.
module hpm_multiply import hpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  unpack_t st_i,
  output mult_t   st_r
);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_i.valid;
    end
    st_r.sign        <= st_i.sign;
    st_r.special     <= st_i.special;
    st_r.special_val <= st_i.special_val;
    st_r.p           <= 22'(st_i.ma) * 22'(st_i.mb);
    st_r.xsum        <= st_i.xsum;
  end
endmodule

@@ src/hpm_align.sv @@
// Stage three: normalise the product and shift right for gradual underflow.
// Depends on hpm_pkg.
module hpm_align import hpm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  mult_t  st_i,
  output align_t st_r
);
  align_t st_nxt;
  logic [5:0] sh;
  logic signed [7:0] be;
  logic [33:0] ext;
  logic [33:0] shifted;

  always_comb begin
    be = st_i.xsum + 8'sd15 + (st_i.p[21] ? 8'sd1 : 8'sd0);
    sh = st_i.p[21] ? 6'd11 : 6'd10;
    st_nxt = '0;
    st_nxt.valid = st_i.valid;
    st_nxt.sign = st_i.sign;
    st_nxt.special = st_i.special;
    st_nxt.special_val = st_i.special_val;
    st_nxt.be = be;
    if (be < 8'sd1) begin
      st_nxt.sub = 1'b1;
      if ((8'sd1 - be) > 8'sd25) sh = 6'd34;
      else sh = sh + 6'(8'sd1 - be);
    end
    // Product placed at the top of a wide word; shift down and collect the tail.
    ext = {st_i.p, 12'd0};
    shifted = ext >> sh;
    // Integer part sits in bits 23..12 of the shifted word.
    st_nxt.q = shifted[23:12];
    st_nxt.guard = shifted[11];
    st_nxt.sticky = (shifted[10:0] != 11'd0) || ((ext & ~(34'h3FFFFFFFF << sh)) != 34'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    {st_r.sign, st_r.special, st_r.special_val, st_r.sub, st_r.q, st_r.guard,
     st_r.sticky, st_r.be} <=
      {st_nxt.sign, st_nxt.special, st_nxt.special_val, st_nxt.sub, st_nxt.q,
       st_nxt.guard, st_nxt.sticky, st_nxt.be};
  end
endmodule

@@ src/hpm_round.sv @@
// Stage four: round to nearest even, overflow handling and result packing.
// Depends on hpm_pkg.
module hpm_round import hpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  align_t      st_i,
  output logic        valid_r,
  output logic [15:0] product_r
);
  logic [11:0] q;
  logic signed [7:0] be;
  logic [15:0] product_nxt;

  always_comb begin
    q = st_i.q;
    if (st_i.guard && (st_i.sticky || q[0])) q = q + 12'd1;
    be = st_i.be;
    if (st_i.special) begin
      product_nxt = st_i.special_val;
    end else if (st_i.sub) begin
      product_nxt = {st_i.sign, q[10:0] == 11'd0 && !q[11] ? 15'd0 : {4'd0, q[10:0]}};
    end else begin
      if (q == 12'h800) begin
        q = 12'h400; be = be + 8'sd1;
      end
      if (be >= 8'sd31) product_nxt = {st_i.sign, HALF_POS_INF[14:0]};
      else product_nxt = {st_i.sign, be[4:0], q[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= st_i.valid;
    end
    product_r <= product_nxt;
  end
endmodule

@@ src/half_precision_multiplier_unit.sv @@
// Top level of the binary16 multiplier: four pipeline stages.
// Depends on hpm_pkg, hpm_unpack, hpm_multiply, hpm_align and hpm_round.
//
// Usage. Raise start with in_operand_a and in_operand_b; the transaction is
// accepted at the rising edge where start is high and busy is low. busy is
// tied low, so one operand pair may be accepted in every cycle.
// Each result appears on out_product for exactly one cycle, marked by
// out_strobe, once its transaction has passed all four register stages;
// results leave in the order of acceptance. The register stages are:
// decode with subnormal normalisation, the 11 by 11 significand multiply,
// normalisation and underflow alignment, then rounding and packing.
// Throughput is one result per cycle.
// The receiver cannot stall, so there is no back pressure: results must be
// taken in the cycle they are shown.
// Reset (rst_n low, synchronous) clears every stage valid bit, so nothing in
// flight survives it and no strobe follows; payload registers are not reset.
// NaN results are the canonical 0x7FFF; overflow gives signed infinity.
module half_precision_multiplier_unit import hpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  output logic        out_strobe,
  output logic [15:0] out_product
);
  unpack_t s1;
  mult_t   s2;
  align_t  s3;

  // The pipeline never stalls, so it always takes a new transaction.
  assign busy = 1'b0;

  hpm_unpack u_unpack (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
    .operand_a(in_operand_a), .operand_b(in_operand_b), .st_r(s1)
  );
  hpm_multiply u_multiply (.clk(clk), .rst_n(rst_n), .st_i(s1), .st_r(s2));
  hpm_align    u_align    (.clk(clk), .rst_n(rst_n), .st_i(s2), .st_r(s3));
  hpm_round    u_round    (
    .clk(clk), .rst_n(rst_n), .st_i(s3), .valid_r(out_strobe), .product_r(out_product)
  );
endmodule

@@ src/hpm_checker.sv @@
// Port-level checker for the binary16 multiplier, bound to the top level.
// Depends on half_precision_multiplier_unit.
module hpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_operand_a,
  input logic [15:0] in_operand_b,
  input logic        out_strobe,
  input logic [15:0] out_product
);
  // Every accepted transaction yields its result strobe, unless reset comes in between.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 (out_strobe || !$past(rst_n, 1) || !$past(rst_n, 2) ||
                              !$past(rst_n, 3)))
    else $error("missing result strobe");
  // No strobe without an earlier accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 4))
    else $error("spurious result strobe");
  // A NaN in operand a gives the canonical NaN.
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operand_a[14:10] == 5'd31 && in_operand_a[9:0] != 10'd0)
    |-> ##4 (!out_strobe || out_product == 16'h7FFF))
    else $error("NaN not propagated");
endmodule

bind half_precision_multiplier_unit hpm_checker u_hpm_checker (.*);
